@@ hw/rtl/zetc_pkg.sv @@
// ----------------------------------------------------------------------------
// zetc_pkg
// Shared types and constants for the zero-error tick time-of-day clock.
// ----------------------------------------------------------------------------
`default_nettype none

package zetc_pkg;

  localparam int unsigned AccW  = 32;
  localparam int unsigned TrimW = 16;
  localparam int unsigned CfgW  = 32;
  localparam int unsigned SecW  = 6;
  localparam int unsigned MinW  = 6;
  localparam int unsigned HourW = 5;
  localparam int unsigned DayW  = 8;

  localparam logic [AccW-1:0]  TickSpan      = 32'h0001_0000;
  localparam logic [AccW-1:0]  TriggerReset  = 32'd1000000;
  localparam logic [TrimW-1:0] TrimReset     = 16'd0;

  localparam logic [SecW-1:0]  SecsPerMin    = 6'd60;
  localparam logic [MinW-1:0]  MinsPerHour   = 6'd60;
  localparam logic [HourW-1:0] HoursPerDay   = 5'd24;

  localparam logic [SecW-1:0]  SecReset      = 6'd58;
  localparam logic [MinW-1:0]  MinReset      = 6'd59;
  localparam logic [HourW-1:0] HourReset     = 5'd23;
  localparam logic [DayW-1:0]  DayReset      = 8'd0;

  typedef enum logic [0:0] {
    RegTriggerPeriod = 1'b0,
    RegTrimError     = 1'b1
  } cfg_reg_e;

endpackage

`default_nettype wire

@@ hw/rtl/zero_error_tick_time_of_day_clock_top.sv @@
// ----------------------------------------------------------------------------
// zero_error_tick_time_of_day_clock_top
// Time-of-day clock driven by timer overflow beats with a trimmed
// accumulator, so that the long-term error stays at zero.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                payload
//  in        input      in_valid_i / in_ready_o  overflow_tick_i
//  out       output     out_valid_o / out_ready_i step_pulse_o, half_second_o,
//                                                seconds_o, minutes_o, hours_o,
//                                                days_o
//  cfg       input      cfg_we_i                 cfg_idx_i, cfg_wdata_i
//
//  one beat in, one beat out; each beat is registered into the result register
//  a new beat is taken every cycle while the result register is empty or drained
//  the accumulator add, trigger compare and subtract plus the time counter
//  cascade are all combinational, ahead of the state and result registers
//  reset: accumulator 0, time 23:59:58.0 day 0, trigger 1000000, trim 0
//  a stalled output holds its beat and blocks the input until taken
// ----------------------------------------------------------------------------
`default_nettype none

module zero_error_tick_time_of_day_clock_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [0:0]                      cfg_idx_i,
  input  logic [zetc_pkg::CfgW-1:0]       cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            overflow_tick_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            step_pulse_o,
  output logic                            half_second_o,
  output logic [zetc_pkg::SecW-1:0]       seconds_o,
  output logic [zetc_pkg::MinW-1:0]       minutes_o,
  output logic [zetc_pkg::HourW-1:0]      hours_o,
  output logic [zetc_pkg::DayW-1:0]       days_o
);

  logic [zetc_pkg::AccW-1:0]  trigger_q;
  logic [zetc_pkg::TrimW-1:0] trim_q;

  logic [zetc_pkg::AccW-1:0]  acc_q, acc_d;
  logic                       half_q, half_d;
  logic [zetc_pkg::SecW-1:0]  sec_q, sec_d;
  logic [zetc_pkg::MinW-1:0]  min_q, min_d;
  logic [zetc_pkg::HourW-1:0] hour_q, hour_d;
  logic [zetc_pkg::DayW-1:0]  day_q, day_d;

  logic                       out_valid_q;
  logic                       pulse_q, pulse_d;
  logic                       ohalf_q;
  logic [zetc_pkg::SecW-1:0]  osec_q;
  logic [zetc_pkg::MinW-1:0]  omin_q;
  logic [zetc_pkg::HourW-1:0] ohour_q;
  logic [zetc_pkg::DayW-1:0]  oday_q;

  logic                       in_fire;
  logic                       tick;
  logic [zetc_pkg::AccW-1:0]  trim_ext;
  logic [zetc_pkg::AccW-1:0]  acc_sum;
  logic [zetc_pkg::SecW-1:0]  sec_inc;
  logic [zetc_pkg::MinW-1:0]  min_inc;
  logic [zetc_pkg::HourW-1:0] hour_inc;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign tick       = in_fire && overflow_tick_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trigger_q <= zetc_pkg::TriggerReset;
      trim_q    <= zetc_pkg::TrimReset;
    end else if (cfg_we_i) begin
      case (zetc_pkg::cfg_reg_e'(cfg_idx_i))
        zetc_pkg::RegTriggerPeriod: trigger_q <= cfg_wdata_i;
        zetc_pkg::RegTrimError:     trim_q    <= cfg_wdata_i[zetc_pkg::TrimW-1:0];
        default: ;
      endcase
    end
  end

  assign trim_ext = {{(zetc_pkg::AccW-zetc_pkg::TrimW){trim_q[zetc_pkg::TrimW-1]}}, trim_q};
  assign acc_sum  = acc_q + zetc_pkg::TickSpan + trim_ext;
  assign sec_inc  = sec_q + 1'b1;
  assign min_inc  = min_q + 1'b1;
  assign hour_inc = hour_q + 1'b1;

  always_comb begin
    acc_d   = acc_q;
    half_d  = half_q;
    sec_d   = sec_q;
    min_d   = min_q;
    hour_d  = hour_q;
    day_d   = day_q;
    pulse_d = 1'b0;
    if (tick) begin
      acc_d = acc_sum;
      if (acc_sum >= trigger_q) begin
        acc_d   = acc_sum - trigger_q;
        pulse_d = 1'b1;
        // carry cascade: half-second, seconds, minutes, hours, days
        half_d  = !half_q;
        if (half_q) begin
          sec_d = sec_inc;
          if (sec_inc >= zetc_pkg::SecsPerMin) begin
            sec_d = '0;
            min_d = min_inc;
            if (min_inc >= zetc_pkg::MinsPerHour) begin
              min_d  = '0;
              hour_d = hour_inc;
              if (hour_inc >= zetc_pkg::HoursPerDay) begin
                hour_d = '0;
                day_d  = day_q + 1'b1;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      half_q <= 1'b0;
      sec_q  <= zetc_pkg::SecReset;
      min_q  <= zetc_pkg::MinReset;
      hour_q <= zetc_pkg::HourReset;
      day_q  <= zetc_pkg::DayReset;
    end else begin
      acc_q  <= acc_d;
      half_q <= half_d;
      sec_q  <= sec_d;
      min_q  <= min_d;
      hour_q <= hour_d;
      day_q  <= day_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pulse_q <= pulse_d;
      ohalf_q <= half_d;
      osec_q  <= sec_d;
      omin_q  <= min_d;
      ohour_q <= hour_d;
      oday_q  <= day_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign step_pulse_o  = pulse_q;
  assign half_second_o = ohalf_q;
  assign seconds_o     = osec_q;
  assign minutes_o     = omin_q;
  assign hours_o       = ohour_q;
  assign days_o        = oday_q;

endmodule

`default_nettype wire

@@ hw/rtl/zetc_checker.sv @@
// ----------------------------------------------------------------------------
// zetc_checker
// Port-level checks for the zero-error tick time-of-day clock.
// ----------------------------------------------------------------------------
`default_nettype none

module zetc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic                            step_pulse_o,
  input logic                            half_second_o,
  input logic [zetc_pkg::SecW-1:0]       seconds_o,
  input logic [zetc_pkg::MinW-1:0]       minutes_o,
  input logic [zetc_pkg::HourW-1:0]      hours_o,
  input logic [zetc_pkg::DayW-1:0]       days_o
);

  // a held result beat keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(step_pulse_o)
      && $stable(half_second_o) && $stable(seconds_o) && $stable(minutes_o)
      && $stable(hours_o) && $stable(days_o))
    else $error("stalled result beat changed");

  // every accepted input beat shows up as a result beat next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted beat produced no result");

  // an empty result stage never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result stage");

  // taken result with no new input leaves the stage empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !in_valid_i |=> !out_valid_o)
    else $error("result beat repeated");

  // time fields stay inside their ranges
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> seconds_o < zetc_pkg::SecsPerMin
      && minutes_o < zetc_pkg::MinsPerHour && hours_o < zetc_pkg::HoursPerDay)
    else $error("time field out of range");

endmodule

bind zero_error_tick_time_of_day_clock_top zetc_checker u_zetc_checker (.*);

`default_nettype wire
